[src/fci_pkg.sv]
`default_nettype none

package fci_pkg;

  localparam int MAX_POINTS       = 6;
  localparam int CURVE_POINTS_DEF = 6;
  localparam int PT_W             = 8;
  localparam int CFG_W            = MAX_POINTS * PT_W;
  localparam int CFG_IDX_W        = 2;
  localparam int CNT_W            = 3;
  localparam int TEMP_W           = 18;
  localparam int DEG_W            = 9;
  localparam int PCT_W            = 7;
  localparam int DUTY_W           = 8;

  localparam logic [CFG_W-1:0] TEMP_POINTS_RESET  = 48'h4A463C321E00;
  localparam logic [CFG_W-1:0] SPEED_POINTS_RESET = 48'h6446281E1919;
  localparam logic [CNT_W-1:0] POINTS_RESET       = 3'd6;

  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [12:0]      DUTY_RECIP = 13'd5243;
  localparam int               DUTY_SHIFT = 19;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_POINTS   = 2'd0,
    REG_SPEED_POINTS  = 2'd1,
    REG_POINTS_IN_USE = 2'd2
  } cfg_reg_t;

  // One classified segment; an end of the curve is given as a flat segment.
  typedef struct packed {
    logic            neg;
    logic [PT_W-1:0] mag_dy;
    logic [PT_W-1:0] dt;
    logic [PT_W-1:0] dx;
    logic [PT_W-1:0] y1;
  } seg_item_t;

  function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = 15'(pct) * 15'd255;
    prod   = 28'(scaled) * 28'(DUTY_RECIP);
    return prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
  endfunction

endpackage

`default_nettype wire

[src/fci_if.sv]
`default_nettype none

interface fci_in_if import fci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temp_millideg;

  modport source (output valid, output temp_millideg, input ready);
  modport sink   (input valid, input temp_millideg, output ready);
endinterface

interface fci_out_if import fci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PCT_W-1:0]  fan_percent;
  logic [DUTY_W-1:0] pwm_duty;

  modport source (output valid, output fan_percent, output pwm_duty, input ready);
  modport sink   (input valid, input fan_percent, input pwm_duty, output ready);
endinterface

`default_nettype wire

[src/fci_front.sv]
`default_nettype none

module fci_front import fci_pkg::*; #(
  parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  fci_in_if.sink                in_ch,
  input  wire logic [CFG_W-1:0] temp_points,
  input  wire logic [CFG_W-1:0] speed_points,
  input  wire logic [CNT_W-1:0] points_in_use,
  input  wire logic             q_full,
  output logic                  push,
  output seg_item_t             item
);

  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(CURVE_POINTS);

  logic                     front_en;
  logic                     s1_vld_r;
  logic [DEG_W-1:0]         t_r;
  logic                     s2_vld_r;
  seg_item_t                item_r;
  seg_item_t                item_nxt;
  logic [TEMP_W+18:0]       recip_prod;
  logic [CNT_W-1:0]         n_pts;

  assign front_en    = !s2_vld_r || !q_full;
  assign in_ch.ready = front_en;
  assign recip_prod  = (TEMP_W + 19)'(in_ch.temp_millideg) * (TEMP_W + 19)'(RECIP_1000);

  always_comb begin
    if (points_in_use < 3'd2) begin
      n_pts = 3'd2;
    end else if (points_in_use > N_MAX) begin
      n_pts = N_MAX;
    end else begin
      n_pts = points_in_use;
    end
  end

  always_comb begin
    logic [PT_W-1:0]  x1;
    logic [PT_W-1:0]  x2;
    logic [PT_W-1:0]  y1;
    logic [PT_W-1:0]  y2;
    logic [PT_W-1:0]  y_end;
    logic [PT_W:0]    dy;
    logic [DEG_W-1:0] dt9;
    y_end = speed_points[PT_W-1:0];
    for (int k = 0; k < CURVE_POINTS; k++) begin
      if (CNT_W'(k) == n_pts - 3'd1) begin
        y_end = speed_points[PT_W*k +: PT_W];
      end
    end
    item_nxt.neg    = 1'b0;
    item_nxt.mag_dy = '0;
    item_nxt.dt     = '0;
    item_nxt.dx     = PT_W'(1);
    item_nxt.y1     = (t_r <= {1'b0, temp_points[PT_W-1:0]}) ?
                      speed_points[PT_W-1:0] : y_end;
    // Walk downwards so that the lowest matching segment wins.
    for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
      x1  = temp_points[PT_W*i +: PT_W];
      x2  = temp_points[PT_W*(i+1) +: PT_W];
      y1  = speed_points[PT_W*i +: PT_W];
      y2  = speed_points[PT_W*(i+1) +: PT_W];
      dy  = {1'b0, y2} - {1'b0, y1};
      dt9 = t_r - {1'b0, x1};
      if ((CNT_W'(i) < n_pts - 3'd1) && (t_r > {1'b0, x1}) && (t_r <= {1'b0, x2})) begin
        item_nxt.neg    = dy[PT_W];
        item_nxt.mag_dy = dy[PT_W] ? (~dy[PT_W-1:0] + PT_W'(1)) : dy[PT_W-1:0];
        item_nxt.dt     = dt9[PT_W-1:0];
        item_nxt.dx     = x2 - x1;
        item_nxt.y1     = y1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (front_en) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      t_r    <= recip_prod[RECIP_SHIFT+DEG_W-1:RECIP_SHIFT];
      item_r <= item_nxt;
    end
  end

  assign push = s2_vld_r && !q_full;
  assign item = item_r;

endmodule

`default_nettype wire

[src/fci_fifo.sv]
`default_nettype none

module fci_fifo import fci_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire seg_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output seg_item_t      head_item,
  output logic           empty
);

  seg_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;
  logic [Q_PTR_W:0]     count_nxt;

  assign full      = count_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign empty     = count_r == '0;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[src/fci_back.sv]
`default_nettype none

module fci_back import fci_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire seg_item_t head_item,
  input  wire logic      q_empty,
  output logic           pop,
  fci_out_if.source      out_ch
);

  localparam int DIV_STAGES = PT_W;
  localparam int NUM_W      = 2 * PT_W;

  logic                  back_en;
  logic [DIV_STAGES:0]   vld_r;
  logic [NUM_W-1:0]      num_r [DIV_STAGES+1];
  logic [PT_W-1:0]       quo_r [DIV_STAGES+1];
  logic [PT_W-1:0]       dx_r  [DIV_STAGES+1];
  logic [PT_W-1:0]       y1_r  [DIV_STAGES+1];
  logic [DIV_STAGES:0]   neg_r;
  logic [NUM_W-1:0]      dsh   [DIV_STAGES];
  logic [DIV_STAGES-1:0] ge;
  logic                  c_vld_r;
  logic [PCT_W-1:0]      pct_r;
  logic [PCT_W-1:0]      pct_nxt;
  logic signed [10:0]    sum;
  logic                  out_vld_r;
  logic [PCT_W-1:0]      fan_r;
  logic [DUTY_W-1:0]     duty_r;

  assign back_en = !out_vld_r || out_ch.ready;
  assign pop     = back_en && !q_empty;

  // Restoring division, one quotient bit a stage, most significant first.
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dsh[k] = NUM_W'(dx_r[k]) << (DIV_STAGES - 1 - k);
      ge[k]  = num_r[k] >= dsh[k];
    end
  end

  always_comb begin
    if (neg_r[DIV_STAGES]) begin
      sum = $signed({3'b000, y1_r[DIV_STAGES]}) - $signed({3'b000, quo_r[DIV_STAGES]});
    end else begin
      sum = $signed({3'b000, y1_r[DIV_STAGES]}) + $signed({3'b000, quo_r[DIV_STAGES]});
    end
    if (sum[10]) begin
      pct_nxt = '0;
    end else if (sum > $signed(11'(PCT_MAX))) begin
      pct_nxt = PCT_MAX;
    end else begin
      pct_nxt = sum[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (back_en) begin
      vld_r     <= {vld_r[DIV_STAGES-1:0], pop};
      c_vld_r   <= vld_r[DIV_STAGES];
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      num_r[0] <= NUM_W'(head_item.mag_dy) * NUM_W'(head_item.dt);
      quo_r[0] <= '0;
      dx_r[0]  <= head_item.dx;
      y1_r[0]  <= head_item.y1;
      neg_r[0] <= head_item.neg;
      for (int k = 0; k < DIV_STAGES; k++) begin
        num_r[k+1] <= ge[k] ? (num_r[k] - dsh[k]) : num_r[k];
        quo_r[k+1] <= {quo_r[k][PT_W-2:0], ge[k]};
        dx_r[k+1]  <= dx_r[k];
        y1_r[k+1]  <= y1_r[k];
        neg_r[k+1] <= neg_r[k];
      end
      pct_r  <= pct_nxt;
      fan_r  <= pct_r;
      duty_r <= pct_to_duty(pct_r);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.fan_percent = fan_r;
  assign out_ch.pwm_duty    = duty_r;

endmodule

`default_nettype wire

[src/fan_curve_interpolator.sv]
`default_nettype none

// Words pass the temperature and segment registers, the queue, the divider and the outputs.
// One word per cycle unless the output stalls; the eight-stage divider and queue keep pace.
// Reset (synchronous, active low) empties the pipeline and the queue and loads the
// default curve of six points. No clearing pass is needed; words are taken at once.
module fan_curve_interpolator import fci_pkg::*; #(
  parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  fci_in_if.sink                    in_ch,
  fci_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] temp_points_r;
  logic [CFG_W-1:0] speed_points_r;
  logic [CNT_W-1:0] points_in_use_r;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  seg_item_t        push_item;
  seg_item_t        head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_points_r   <= TEMP_POINTS_RESET;
      speed_points_r  <= SPEED_POINTS_RESET;
      points_in_use_r <= POINTS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEMP_POINTS: begin
          temp_points_r <= cfg_data;
        end
        REG_SPEED_POINTS: begin
          speed_points_r <= cfg_data;
        end
        REG_POINTS_IN_USE: begin
          points_in_use_r <= cfg_data[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fci_front #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .temp_points   (temp_points_r),
    .speed_points  (speed_points_r),
    .points_in_use (points_in_use_r),
    .q_full        (q_full),
    .push          (push),
    .item          (push_item)
  );

  fci_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  fci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[test/fan_curve_checker.sv]
`timescale 1ns / 1ps

module fan_curve_checker import fci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fci_in_if                    in_ch,
  fci_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   failures,
  output int                   pending
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [PCT_W-1:0]  pct;
    logic [DUTY_W-1:0] duty;
  } fan_setting_t;

  logic [CFG_W-1:0] temp_curve;
  logic [CFG_W-1:0] speed_curve;
  logic [CNT_W-1:0] curve_count;
  fan_setting_t     expected_settings[$];

  task automatic report_fault(input string msg);
    if (failures < PRINT_LIMIT) begin
      $display("[%0t] %s", $time, msg);
    end
    failures++;
  endtask

  function automatic fan_setting_t predict_fan_setting(input logic [TEMP_W-1:0] temp_millideg);
    fan_setting_t setting;
    int deg;
    int used;
    int seg;
    int x1;
    int x2;
    int y1;
    int y2;
    int pct;
    bit hit;
    deg  = int'(temp_millideg) / 1000;
    used = int'(curve_count);
    if (used > CURVE_POINTS_DEF) begin
      used = CURVE_POINTS_DEF;
    end
    if (used < 2) begin
      used = 2;
    end
    hit = 1'b0;
    pct = 0;
    for (seg = 0; seg < used - 1 && !hit; seg++) begin
      x1 = int'(temp_curve[PT_W*seg +: PT_W]);
      x2 = int'(temp_curve[PT_W*(seg+1) +: PT_W]);
      if (deg > x1 && deg <= x2) begin
        y1  = int'(speed_curve[PT_W*seg +: PT_W]);
        y2  = int'(speed_curve[PT_W*(seg+1) +: PT_W]);
        pct = y1 + ((y2 - y1) * (deg - x1)) / (x2 - x1);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (deg <= int'(temp_curve[PT_W-1:0])) begin
        pct = int'(speed_curve[PT_W-1:0]);
      end else begin
        pct = int'(speed_curve[PT_W*(used-1) +: PT_W]);
      end
    end
    if (pct < 0) begin
      pct = 0;
    end
    if (pct > 100) begin
      pct = 100;
    end
    setting.temp = temp_millideg;
    setting.pct  = PCT_W'(pct);
    setting.duty = DUTY_W'(pct * 255 / 100);
    return setting;
  endfunction

  always @(posedge clk) begin
    fan_setting_t want;
    if (!rst_n) begin
      temp_curve  = TEMP_POINTS_RESET;
      speed_curve = SPEED_POINTS_RESET;
      curve_count = POINTS_RESET;
      expected_settings.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_settings.size() == 0) begin
          report_fault($sformatf("result word with nothing expected: percent %0d, duty %0d",
                                 out_ch.fan_percent, out_ch.pwm_duty));
        end else begin
          want = expected_settings.pop_front();
          if (out_ch.fan_percent !== want.pct) begin
            report_fault($sformatf("fan_percent %0d, expected %0d for %0d millidegrees",
                                   out_ch.fan_percent, want.pct, want.temp));
          end
          if (out_ch.pwm_duty !== want.duty) begin
            report_fault($sformatf("pwm_duty %0d, expected %0d for %0d millidegrees",
                                   out_ch.pwm_duty, want.duty, want.temp));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_settings.push_back(predict_fan_setting(in_ch.temp_millideg));
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TEMP_POINTS: begin
            temp_curve = cfg_data;
          end
          REG_SPEED_POINTS: begin
            speed_curve = cfg_data;
          end
          REG_POINTS_IN_USE: begin
            curve_count = cfg_data[CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_settings.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fci_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TEMP_TOP     = 262143;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   failures;
  int                   pending;
  int                   cycle_count = 0;
  int unsigned          hold_requests = 0;
  logic [CFG_W-1:0]     curve_temps;
  logic [TEMP_W-1:0]    temp_plan[$];

  fci_in_if  in_ch ();
  fci_out_if out_ch ();

  fan_curve_interpolator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fan_curve_checker speed_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls on a rotating pattern that is reloaded now and then, and
  // holds off for a long stretch whenever the sender asks for it.
  initial begin : receiver
    logic [15:0] ready_pattern;
    int unsigned slot;
    int unsigned holds_served;
    int unsigned hold_left;
    ready_pattern = '1;
    slot          = 0;
    holds_served  = 0;
    hold_left     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        slot++;
        if (slot % 64 == 0) begin
          ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0101);
        end
      end
    end
  end

  function automatic logic [TEMP_W-1:0] pick_temp();
    int deg;
    int k;
    case ($urandom_range(0, 3))
      0: begin
        return TEMP_W'($urandom_range(0, TEMP_TOP));
      end
      default: begin
        k   = int'($urandom_range(0, MAX_POINTS - 1));
        deg = int'(curve_temps[PT_W*k +: PT_W]) + int'($urandom_range(0, 2)) - 1;
        if (deg < 0) begin
          deg = 0;
        end
        return TEMP_W'(deg * 1000 + int'($urandom_range(0, 999)));
      end
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] ascending_temps();
    logic [CFG_W-1:0] points;
    int deg;
    int k;
    deg = int'($urandom_range(0, 40));
    for (k = 0; k < MAX_POINTS; k++) begin
      points[PT_W*k +: PT_W] = PT_W'(deg);
      deg += int'($urandom_range(1, 50));
      if (deg > 255) begin
        deg = 255;
      end
    end
    return points;
  endfunction

  function automatic logic [CFG_W-1:0] random_speeds();
    logic [CFG_W-1:0] points;
    int k;
    for (k = 0; k < MAX_POINTS; k++) begin
      points[PT_W*k +: PT_W] = PT_W'($urandom_range(0, 110));
    end
    return points;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) temp_plan.push_back(pick_temp());
  endtask

  task automatic send_plan();
    int burst;
    int gap;
    while (temp_plan.size() != 0) begin
      burst = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                          : int'($urandom_range(1, 8));
      while (burst != 0 && temp_plan.size() != 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.temp_millideg <= temp_plan.pop_front();
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
      if (temp_plan.size() == 0) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end else if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_curve(input logic [CFG_W-1:0] temps, input logic [CFG_W-1:0] speeds,
                               input logic [CNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEMP_POINTS;
    cfg_data  <= temps;
    @(posedge clk);
    cfg_index <= REG_SPEED_POINTS;
    cfg_data  <= speeds;
    @(posedge clk);
    cfg_index <= REG_POINTS_IN_USE;
    cfg_data  <= CFG_W'(count);
    @(posedge clk);
    cfg_we      <= 1'b0;
    curve_temps = temps;
  endtask

  initial begin : stimulus
    int k;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.temp_millideg <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_TEMP_POINTS;
    cfg_data            <= '0;
    curve_temps = TEMP_POINTS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default curve: both ends, each point, and words either side of some points.
    temp_plan = '{0, 999, 1000, 29999, 30000, 30999, 31000, 45500, 50000, 59999,
                  60000, 65432, 70000, 73999, 74000, 74999, 75000, 255999, 256000,
                  TEMP_TOP};
    queue_random(150);
    hold_requests++;
    send_plan();
    settle();

    program_curve('0, '0, 3'd0);
    temp_plan = '{0, 999, 1000, TEMP_TOP};
    queue_random(50);
    send_plan();
    settle();

    program_curve('1, '1, 3'd7);
    temp_plan = '{0, 254999, 255000, 255999, 256000, TEMP_TOP};
    queue_random(50);
    send_plan();
    settle();

    program_curve(48'h00000000_1400, 48'h00000000_0064, 3'd1);
    queue_random(60);
    send_plan();
    settle();

    for (k = 0; k < 4; k++) begin
      program_curve(ascending_temps(), random_speeds(), CNT_W'($urandom_range(2, 6)));
      queue_random(90);
      if (k == 2) begin
        hold_requests++;
      end
      send_plan();
      settle();
    end

    // Points out of order, and speeds above full scale.
    program_curve(48'h321E3C14280A, 48'h64C80AFF5014, 3'd6);
    temp_plan = '{10500, 45000, 52000, 60000, 65000, 30500, 20999};
    queue_random(70);
    send_plan();
    settle();

    program_curve(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                  CNT_W'($urandom_range(0, 7)));
    queue_random(70);
    send_plan();
    settle();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
